@@ src/rsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int OUT_COORD_W    = 16;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int POS_W          = 17;

  localparam logic [7:0]       ROW_END_CODE = 8'h80;
  localparam logic [7:0]       RUN_MASK     = 8'h7f;
  localparam logic [POS_W-1:0] POS_MAX      = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_ROWS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_VERTICAL = 4'd7;

  typedef enum logic [1:0] {
    PH_START,
    PH_SKIP,
    PH_ROWS,
    PH_DONE
  } phase_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DONE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [14:0] visible_width;
    logic [14:0] visible_rows;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [14:0] clip_left;
    logic [14:0] clip_top;
    logic [14:0] sprite_height;
    logic        flip_vertical;
  } cfg_t;

  typedef struct packed {
    kind_e                   kind;
    logic [OUT_COORD_W-1:0]  write_x;
    logic [OUT_COORD_W-1:0]  write_y;
    logic [7:0]              pixel;
  } res_t;

endpackage

`default_nettype wire

@@ src/rsd_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rsd_cfg_regs
  import rsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output      logic                  cfg_ready_o,
  output      cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VISIBLE_WIDTH: cfg_d.visible_width = cfg_data_i[14:0];
        CFG_VISIBLE_ROWS:  cfg_d.visible_rows  = cfg_data_i[14:0];
        CFG_DEST_X:        cfg_d.dest_x        = cfg_data_i;
        CFG_DEST_Y:        cfg_d.dest_y        = cfg_data_i;
        CFG_CLIP_LEFT:     cfg_d.clip_left     = cfg_data_i[14:0];
        CFG_CLIP_TOP:      cfg_d.clip_top      = cfg_data_i[14:0];
        CFG_SPRITE_HEIGHT: cfg_d.sprite_height = cfg_data_i[14:0];
        CFG_FLIP_VERTICAL: cfg_d.flip_vertical = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rsd_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rsd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] src_byte_i,
  output      logic       in_stall_o,
  input  wire logic       take_i,
  output      logic       valid_o,
  output      logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // holding a byte that the decode stage cannot take this cycle
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_i);
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= src_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ src/rsd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rsd_decode
  import rsd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  input  wire logic       free_i,
  output      logic       take_o,
  output      logic       load_o,
  output      res_t       res_o
);

  phase_e           phase_q, phase_d;
  logic [15:0]      skip_q, skip_d;
  logic [15:0]      row_q, row_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [6:0]       lit_q, lit_d;

  logic             emit_pix, emit_done;
  logic [16:0]      flip_skip;
  logic             skip_pos;
  logic [15:0]      skip_init;
  logic [15:0]      skip_dec;
  logic [15:0]      row_inc;
  logic [POS_W:0]   pos_add;
  logic [POS_W:0]   pos_diff;
  logic             in_window;
  logic [15:0]      x_raw, y_raw, x_wrap, y_wrap;

  // rows to discard before drawing, negative treated as none
  assign flip_skip = {2'b0, cfg_i.sprite_height} - {2'b0, cfg_i.clip_top}
                   - {2'b0, cfg_i.visible_rows};
  assign skip_pos  = cfg_i.flip_vertical ? (!flip_skip[16] && (flip_skip != '0))
                                         : (cfg_i.clip_top != '0);
  assign skip_init = cfg_i.flip_vertical ? flip_skip[15:0] : {1'b0, cfg_i.clip_top};

  assign skip_dec = skip_q - 16'd1;
  assign row_inc  = row_q + 16'd1;
  assign pos_add  = {1'b0, pos_q} + {{(POS_W-7){1'b0}}, byte_i};
  assign pos_diff = {1'b0, pos_q} - {3'b0, cfg_i.clip_left};
  assign in_window = !pos_diff[POS_W]
                  && (pos_diff[POS_W-1:0] < {2'b0, cfg_i.visible_width});

  assign x_raw = cfg_i.dest_x + pos_q[15:0] - {1'b0, cfg_i.clip_left};
  assign y_raw = cfg_i.flip_vertical
               ? (cfg_i.dest_y + {1'b0, cfg_i.visible_rows} - 16'd1 - row_q)
               : (cfg_i.dest_y + row_q);

  // narrow coordinate space wraps and sign-extends back to the port width
  generate
    if (COORD_BITS < OUT_COORD_W) begin : g_narrow
      assign x_wrap = {{(OUT_COORD_W-COORD_BITS){x_raw[COORD_BITS-1]}},
                       x_raw[COORD_BITS-1:0]};
      assign y_wrap = {{(OUT_COORD_W-COORD_BITS){y_raw[COORD_BITS-1]}},
                       y_raw[COORD_BITS-1:0]};
    end else begin : g_wide
      assign x_wrap = x_raw;
      assign y_wrap = y_raw;
    end
  endgenerate

  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    row_d     = row_q;
    pos_d     = pos_q;
    lit_d     = lit_q;
    emit_pix  = 1'b0;
    emit_done = 1'b0;

    // first byte picks the starting phase, then is handled in that phase
    if (phase_q == PH_START) begin
      lit_d = '0;
      if (skip_pos) begin
        phase_d = PH_SKIP;
        skip_d  = skip_init;
      end else if (cfg_i.visible_rows != '0) begin
        phase_d = PH_ROWS;
        skip_d  = '0;
        row_d   = '0;
        pos_d   = '0;
      end else begin
        phase_d   = PH_DONE;
        skip_d    = '0;
        emit_done = 1'b1;
      end
    end

    case (phase_d)
      PH_SKIP: begin
        if (phase_q == PH_START || phase_q == PH_SKIP) begin
          if (lit_q != '0 && phase_q == PH_SKIP) begin
            lit_d = lit_q - 7'd1;
          end else if (byte_i > ROW_END_CODE) begin
            lit_d = byte_i[6:0] & RUN_MASK[6:0];
          end else if (byte_i == ROW_END_CODE) begin
            skip_d = (phase_q == PH_START) ? (skip_init - 16'd1) : skip_dec;
            if (skip_d == '0) begin
              row_d = '0;
              pos_d = '0;
              if (cfg_i.visible_rows != '0) begin
                phase_d = PH_ROWS;
              end else begin
                phase_d   = PH_DONE;
                emit_done = 1'b1;
              end
            end
          end
        end
      end
      PH_ROWS: begin
        // rows entered from start see zero literal count
        if (lit_q != '0 && phase_q == PH_ROWS) begin
          lit_d    = lit_q - 7'd1;
          emit_pix = in_window;
          if (pos_q != POS_MAX) begin
            pos_d = pos_q + {{(POS_W-1){1'b0}}, 1'b1};
          end
        end else if (byte_i < ROW_END_CODE) begin
          pos_d = pos_add[POS_W] ? POS_MAX : pos_add[POS_W-1:0];
        end else if (byte_i > ROW_END_CODE) begin
          lit_d = byte_i[6:0] & RUN_MASK[6:0];
        end else begin
          row_d = row_inc;
          pos_d = '0;
          if (row_inc >= {1'b0, cfg_i.visible_rows}) begin
            phase_d   = PH_DONE;
            emit_done = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // a done phase from before this byte swallows it
    if (phase_q == PH_DONE) begin
      phase_d   = PH_DONE;
      skip_d    = skip_q;
      row_d     = row_q;
      pos_d     = pos_q;
      lit_d     = lit_q;
      emit_pix  = 1'b0;
      emit_done = 1'b0;
    end
  end

  assign take_o = valid_i && (free_i || !(emit_pix || emit_done));
  assign load_o = take_o && (emit_pix || emit_done);

  always_comb begin
    res_o = '0;
    if (emit_done) begin
      res_o.kind = KIND_DONE;
    end else begin
      res_o.kind    = KIND_PIXEL;
      res_o.write_x = x_wrap;
      res_o.write_y = y_wrap;
      res_o.pixel   = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      skip_q  <= '0;
      row_q   <= '0;
      pos_q   <= '0;
      lit_q   <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      row_q   <= row_d;
      pos_q   <= pos_d;
      lit_q   <= lit_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rsd_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rsd_out_reg
  import rsd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire res_t                   res_i,
  output      logic                   free_o,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic                   kind_o,
  output      logic [OUT_COORD_W-1:0] write_x_o,
  output      logic [OUT_COORD_W-1:0] write_y_o,
  output      logic [7:0]             pixel_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // slot frees up in the same cycle its transaction completes
  assign free_o      = !valid_q || !out_stall_i;
  assign valid_d     = load_i || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign kind_o      = res_q.kind;
  assign write_x_o   = res_q.write_x;
  assign write_y_o   = res_q.write_y;
  assign pixel_o     = res_q.pixel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ src/rle_sprite_row_decoder_clipped.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o   src_byte_i
// out       output     out_valid_o/out_stall_i kind_o, write_x_o, write_y_o, pixel_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one byte per cycle while the input is not stalled: a byte sits in the input register,
// then the decode stage updates the row counters and fills the result register
// a pixel or done transaction is registered in the result register when the decode stage takes its byte
// reset clears the decode state to the start phase and the config registers to zero
// out_stall_i holds the result register; the input stalls only when a byte
// that makes a result finds the result register still occupied

module rle_sprite_row_decoder_clipped
  import rsd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic [7:0]             src_byte_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic                   kind_o,
  output      logic [OUT_COORD_W-1:0] write_x_o,
  output      logic [OUT_COORD_W-1:0] write_y_o,
  output      logic [7:0]             pixel_o,
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t       cfg;
  logic       take;
  logic       load;
  logic       free;
  logic       byte_valid;
  logic [7:0] byte_q;
  res_t       res;

  rsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  rsd_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .src_byte_i (src_byte_i),
    .in_stall_o (in_stall_o),
    .take_i     (take),
    .valid_o    (byte_valid),
    .byte_o     (byte_q)
  );

  rsd_decode #(
    .COORD_BITS (COORD_BITS)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_valid),
    .byte_i  (byte_q),
    .cfg_i   (cfg),
    .free_i  (free),
    .take_o  (take),
    .load_o  (load),
    .res_o   (res)
  );

  rsd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .write_x_o   (write_x_o),
    .write_y_o   (write_y_o),
    .pixel_o     (pixel_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rsd_pkg::*;

  localparam int         IDLE_PCT    = 19;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         RAND_PHASES = 8;
  localparam int         PHASE_BYTES = 80;
  localparam int         LONG_SKIPS  = 264;
  localparam logic [7:0] MAX_SKIP    = 8'h7f;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic [7:0]            src_byte    = '0;
  logic                  out_stall   = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  wire                   in_stall;
  wire                   out_valid;
  wire                   kind;
  wire [OUT_COORD_W-1:0] write_x;
  wire [OUT_COORD_W-1:0] write_y;
  wire [7:0]             pixel;
  wire                   cfg_ready;

  rle_sprite_row_decoder_clipped dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .src_byte_i  (src_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .write_x_o   (write_x),
    .write_y_o   (write_y),
    .pixel_o     (pixel),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sprite decoder mirror
  cfg_t        window_regs;
  phase_e      dec_phase;
  logic [15:0] rows_left;
  logic [15:0] row_idx;
  logic [16:0] col;
  logic [6:0]  run_left;

  res_t        expected_writes[$];
  logic [7:0]  stream_bytes[$];

  bit          steady = 1'b0;
  int          error_count = 0;
  int          bytes_taken = 0;
  int          pixels_checked = 0;
  int          markers_seen = 0;
  int          cycles = 0;

  function automatic void finish_sprite();
    res_t r;
    dec_phase = PH_DONE;
    r.kind    = KIND_DONE;
    r.write_x = '0;
    r.write_y = '0;
    r.pixel   = '0;
    expected_writes.push_back(r);
  endfunction

  function automatic void enter_rows();
    dec_phase = PH_ROWS;
    row_idx   = '0;
    col       = '0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    int          skip;
    int          lo;
    logic [31:0] x;
    logic [31:0] y;
    res_t        r;
    if (dec_phase == PH_DONE) return;
    if (dec_phase == PH_START) begin
      run_left = '0;
      if (window_regs.flip_vertical)
        skip = int'(window_regs.sprite_height) - int'(window_regs.clip_top)
               - int'(window_regs.visible_rows);
      else
        skip = int'(window_regs.clip_top);
      rows_left = '0;
      if (skip > 0) begin
        rows_left = 16'(skip);
        dec_phase = PH_SKIP;
      end else if (window_regs.visible_rows != 0) begin
        enter_rows();
      end else begin
        // nothing to draw: the first byte only yields the end marker
        finish_sprite();
        return;
      end
    end
    if (dec_phase == PH_SKIP) begin
      if (run_left != 0) begin
        run_left--;
      end else if (b > ROW_END_CODE) begin
        run_left = 7'(b & RUN_MASK);
      end else if (b == ROW_END_CODE) begin
        rows_left--;
        if (rows_left == 0) begin
          if (window_regs.visible_rows != 0) enter_rows();
          else finish_sprite();
        end
      end
      return;
    end
    if (run_left != 0) begin
      run_left--;
      lo = int'(window_regs.clip_left);
      if (int'(col) >= lo && int'(col) < lo + int'(window_regs.visible_width)) begin
        x = 32'(window_regs.dest_x) + 32'(col) - 32'(window_regs.clip_left);
        if (window_regs.flip_vertical)
          y = 32'(window_regs.dest_y) + 32'(window_regs.visible_rows) - 32'd1
              - 32'(row_idx);
        else
          y = 32'(window_regs.dest_y) + 32'(row_idx);
        r.kind    = KIND_PIXEL;
        r.write_x = x[15:0];
        r.write_y = y[15:0];
        r.pixel   = b;
        expected_writes.push_back(r);
      end
      if (col != POS_MAX) col++;
      return;
    end
    if (b < ROW_END_CODE) begin
      // column saturates instead of wrapping
      if (int'(col) + int'(b) > int'(POS_MAX)) col = POS_MAX;
      else col = col + 17'(b);
    end else if (b > ROW_END_CODE) begin
      run_left = 7'(b & RUN_MASK);
    end else begin
      row_idx++;
      col = '0;
      if (row_idx >= 16'(window_regs.visible_rows)) finish_sprite();
    end
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // byte feeder
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(src_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (stream_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          src_byte <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transaction, expected none, got kind %0d x %h y %h pixel %h",
                   $time, kind, write_x, write_y, pixel);
        end else begin
          want = expected_writes.pop_front();
          compare_field("kind", 16'(want.kind), 16'(kind));
          compare_field("write_x", want.write_x, write_x);
          compare_field("write_y", want.write_y, write_y);
          compare_field("pixel", 16'(want.pixel), 16'(pixel));
          if (want.kind == KIND_DONE) markers_seen++;
          else pixels_checked++;
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VISIBLE_WIDTH: window_regs.visible_width = data[14:0];
      CFG_VISIBLE_ROWS:  window_regs.visible_rows  = data[14:0];
      CFG_DEST_X:        window_regs.dest_x        = data;
      CFG_DEST_Y:        window_regs.dest_y        = data;
      CFG_CLIP_LEFT:     window_regs.clip_left     = data[14:0];
      CFG_CLIP_TOP:      window_regs.clip_top      = data[14:0];
      CFG_SPRITE_HEIGHT: window_regs.sprite_height = data[14:0];
      CFG_FLIP_VERTICAL: window_regs.flip_vertical = data[0];
      default: ;
    endcase
  endtask

  // wait until every byte is taken and every expected transaction has come out
  task automatic settle();
    do @(negedge clk_i); while (stream_bytes.size() != 0 || in_valid ||
                                expected_writes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // bit 15 is dropped by the block for 15-bit registers
  function automatic logic [15:0] with_top_noise(input int v);
    return {1'($urandom), 15'(v)};
  endfunction

  function automatic int push_row();
    int n;
    int len;
    int pick;
    n = 0;
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        stream_bytes.push_back(8'($urandom));
        n++;
      end else if (pick < 15) begin
        stream_bytes.push_back(MAX_SKIP);
        n++;
      end else if (pick < 45) begin
        stream_bytes.push_back(8'($urandom_range(0, 12)));
        n++;
      end else begin
        len = (pick < 50) ? $urandom_range(1, 127) : $urandom_range(1, 6);
        stream_bytes.push_back(ROW_END_CODE | 8'(len));
        repeat (len) stream_bytes.push_back(8'($urandom));
        n += len + 1;
      end
    end
    stream_bytes.push_back(ROW_END_CODE);
    return n + 1;
  endfunction

  task automatic load_window(input int k);
    write_reg(CFG_VISIBLE_WIDTH, (k == 0) ? 16'd0 : (k == 1) ? 16'd32767 :
                                 with_top_noise($urandom_range(0, 40)));
    write_reg(CFG_VISIBLE_ROWS, (k == 2) ? 16'd32767 :
                                with_top_noise($urandom_range(1000, 32767)));
    write_reg(CFG_DEST_X, (k == 1) ? 16'h7fff : 16'($urandom));
    write_reg(CFG_DEST_Y, (k == 1) ? 16'h8000 : 16'($urandom));
    write_reg(CFG_CLIP_LEFT, (k == 0) ? 16'd32767 : (k == 1) ? 16'd0 :
                             with_top_noise($urandom_range(0, 20)));
    write_reg(CFG_CLIP_TOP, (k == 0) ? 16'd0 : (k == 1) ? 16'd32767 : 16'($urandom));
    write_reg(CFG_SPRITE_HEIGHT, (k == 0) ? 16'd32767 : (k == 1) ? 16'd0 : 16'($urandom));
    write_reg(CFG_FLIP_VERTICAL, (k == 0) ? 16'd0 : 16'($urandom));
    // unmapped index, must leave the registers alone
    write_reg(4'($urandom_range(8, 15)), 16'($urandom));
  endtask

  localparam logic [7:0] OPENING [25] = '{
    // two rows dropped at the top, literals carrying the row end value as data
    ROW_END_CODE | 8'd3, 8'h80, 8'h80, 8'h80, 8'h05, ROW_END_CODE,
    ROW_END_CODE | 8'd2, 8'h80, 8'hff, ROW_END_CODE,
    // first drawn row: partly clipped run, then a long skip past the window
    8'h00, 8'h02, ROW_END_CODE | 8'd5, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h01,
    MAX_SKIP, ROW_END_CODE | 8'd1, 8'h55, ROW_END_CODE,
    ROW_END_CODE | 8'd1, 8'haa, ROW_END_CODE
  };

  initial begin : stimulus
    int added;
    window_regs = '0;
    dec_phase   = PH_START;
    rows_left   = '0;
    row_idx     = '0;
    col         = '0;
    run_left    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // flipped sprite, two rows to drop: 32767 - 5 - 32760
    write_reg(CFG_VISIBLE_WIDTH, 16'd6);
    write_reg(CFG_VISIBLE_ROWS, 16'd32760);
    write_reg(CFG_DEST_X, 16'h8000);
    write_reg(CFG_DEST_Y, 16'h7fff);
    write_reg(CFG_CLIP_LEFT, 16'd3);
    write_reg(CFG_CLIP_TOP, 16'd5);
    write_reg(CFG_SPRITE_HEIGHT, 16'd32767);
    write_reg(CFG_FLIP_VERTICAL, 16'd1);
    foreach (OPENING[i]) stream_bytes.push_back(OPENING[i]);
    settle();

    for (int k = 0; k < RAND_PHASES; k++) begin
      load_window(k);
      steady = (k == 2);
      if (k == 3) begin
        // a long skip carries the column past the right edge of the widest window
        write_reg(CFG_CLIP_LEFT, 16'd0);
        write_reg(CFG_VISIBLE_WIDTH, 16'd32767);
        repeat (run_left) stream_bytes.push_back(8'($urandom));
        stream_bytes.push_back(ROW_END_CODE);
        repeat (LONG_SKIPS) stream_bytes.push_back(MAX_SKIP);
        stream_bytes.push_back(ROW_END_CODE | 8'd3);
        repeat (3) stream_bytes.push_back(8'($urandom));
        stream_bytes.push_back(MAX_SKIP);
        stream_bytes.push_back(ROW_END_CODE);
      end
      added = 0;
      while (added < PHASE_BYTES) added += push_row();
      settle();
      steady = 1'b0;
    end

    // zero rows left: the next row end closes the sprite
    write_reg(CFG_VISIBLE_ROWS, 16'd0);
    added = push_row();
    do begin
      settle();
      if (dec_phase != PH_DONE) stream_bytes.push_back(ROW_END_CODE);
    end while (dec_phase != PH_DONE);
    // bytes after the end marker are dropped
    repeat (24) stream_bytes.push_back(8'($urandom));
    settle();
    repeat (8) @(posedge clk_i);

    $display("decoded %0d stream bytes through %0d drawn rows", bytes_taken, row_idx);
    $display("checked %0d pixel writes and %0d end markers", pixels_checked, markers_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rsd_pkg.sv
src/rsd_cfg_regs.sv
src/rsd_in_reg.sv
src/rsd_decode.sv
src/rsd_out_reg.sv
src/rle_sprite_row_decoder_clipped.sv
tb/testbench.sv
